FILE: hdl/bsfr_pkg.sv
package bsfr_pkg;

  // Line framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Register reset values
  localparam logic [7:0] EXP_ADDR_RST    = 8'h03;
  localparam logic [8:0] MAX_PAYLOAD_RST = 9'd250;

  localparam int PAYLOAD_LIMIT_DEF = 256;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_HDR_ERR  = 3'd2,
    ST_DATA_ERR = 3'd3,
    ST_BAD_ESC  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] exp_addr;
    logic [8:0] max_payload;
  } cfg_t;

endpackage

FILE: hdl/bsfr_ifs.sv
interface bsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic [7:0] control_byte;
  logic [8:0] frame_length;

  modport source (output valid, output status, output data_byte, output control_byte,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input data_byte, input control_byte,
                  input frame_length, output ready);
endinterface

interface bsfr_cfg_if;
  import bsfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [8:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bsfr_cfg_regs.sv
module bsfr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  bsfr_cfg_if.sink          cfg_if,
  output bsfr_pkg::cfg_t    cfg
);
  import bsfr_pkg::*;

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_addr    <= EXP_ADDR_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_EXP_ADDR:    cfg_r.exp_addr    <= cfg_if.data[7:0];
        REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_if.data;
      endcase
    end
  end

endmodule

FILE: hdl/bsfr_deframer.sv
module bsfr_deframer #(
  parameter int PAYLOAD_LIMIT = bsfr_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bsfr_pkg::cfg_t cfg,
  bsfr_in_if.sink        in_if,
  bsfr_out_if.source     out_if
);
  import bsfr_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_LIMIT + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(PAYLOAD_LIMIT);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HDR  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // input stage
  logic       stg_v_r;
  logic [7:0] stg_byte_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [7:0]       par_r, par_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic       out_v_r;
  status_t    out_st_r;
  logic [7:0] out_data_r;
  logic [7:0] out_ctrl_r;
  logic [8:0] out_len_r;

  logic       res_v;
  status_t    res_st;
  logic [7:0] res_data;
  logic [8:0] res_len;

  logic       advance;
  logic [7:0] b;
  logic       dst_ok;
  logic [7:0] dst_val;
  logic       hdr_chk;
  logic [7:0] hdr_d;
  logic       take;
  logic [7:0] take_d;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] mp_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign advance     = stg_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !stg_v_r || advance;

  assign b       = stg_byte_r;
  assign dst_ok  = (b == (FLAG_BYTE ^ ESC_XOR)) || (b == (ESC_BYTE ^ ESC_XOR));
  assign dst_val = b ^ ESC_XOR;
  assign mp_ext  = CMP_W'(cfg.max_payload);
  assign cnt_ext = CMP_W'(cnt_r);
  assign limit   = (mp_ext < LIMIT_C) ? mp_ext : LIMIT_C;

  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    ctrl_nxt   = ctrl_r;
    par_nxt    = par_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    cnt_nxt    = cnt_r;
    res_v      = 1'b0;
    res_st     = ST_BYTE;
    res_data   = 8'h00;
    res_len    = 9'd0;
    hdr_chk    = 1'b0;
    hdr_d      = b;
    take       = 1'b0;
    take_d     = b;

    unique case (phase_r)
      PH_ADDR: begin
        if (b == cfg.exp_addr) begin
          phase_nxt = PH_CTRL;
        end else if (b != FLAG_BYTE) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CTRL: begin
        ctrl_nxt  = b;
        esc_nxt   = 1'b0;
        phase_nxt = PH_HDR;
      end
      PH_HDR: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (b == FLAG_BYTE) begin
            phase_nxt = PH_ADDR;
            res_v     = 1'b1;
            res_st    = ST_BAD_ESC;
          end else if (!dst_ok) begin
            phase_nxt = PH_HUNT;
            res_v     = 1'b1;
            res_st    = ST_BAD_ESC;
          end else begin
            hdr_chk = 1'b1;
            hdr_d   = dst_val;
          end
        end else if (b == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else if (b == FLAG_BYTE) begin
          phase_nxt = PH_ADDR;
        end else begin
          hdr_chk = 1'b1;
        end
        if (hdr_chk) begin
          if (hdr_d == (cfg.exp_addr ^ ctrl_r)) begin
            phase_nxt  = PH_DATA;
            par_nxt    = 8'h00;
            held_nxt   = 8'h00;
            held_v_nxt = 1'b0;
            cnt_nxt    = '0;
          end else begin
            phase_nxt = PH_HUNT;
            res_v     = 1'b1;
            res_st    = ST_HDR_ERR;
          end
        end
      end
      PH_DATA: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (b == FLAG_BYTE) begin
            phase_nxt  = PH_ADDR;
            held_v_nxt = 1'b0;
            res_v      = 1'b1;
            res_st     = ST_BAD_ESC;
          end else if (!dst_ok) begin
            phase_nxt  = PH_HUNT;
            held_v_nxt = 1'b0;
            res_v      = 1'b1;
            res_st     = ST_BAD_ESC;
          end else begin
            take   = 1'b1;
            take_d = dst_val;
          end
        end else if (b == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else if (b == FLAG_BYTE) begin
          // closing flag: held byte is the check byte
          phase_nxt  = PH_ADDR;
          held_v_nxt = 1'b0;
          res_v      = 1'b1;
          if (held_v_r && (held_r == par_r)) begin
            res_st  = ST_GOOD;
            res_len = cnt_ext[8:0];
          end else begin
            res_st = ST_DATA_ERR;
          end
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        phase_nxt = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
        esc_nxt   = 1'b0;
      end
    endcase

    // release the held byte and hold the new one, or report an overflow at the limit
    if (take) begin
      if (held_v_r && (cnt_ext >= limit)) begin
        phase_nxt  = PH_HUNT;
        held_v_nxt = 1'b0;
        res_v      = 1'b1;
        res_st     = ST_OVERFLOW;
      end else begin
        if (held_v_r) begin
          res_v    = 1'b1;
          res_st   = ST_BYTE;
          res_data = held_r;
          par_nxt  = par_r ^ held_r;
          cnt_nxt  = cnt_r + 1'b1;
        end
        held_nxt   = take_d;
        held_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_HUNT;
      esc_r    <= 1'b0;
      ctrl_r   <= 8'h00;
      par_r    <= 8'h00;
      held_r   <= 8'h00;
      held_v_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (in_if.ready) begin
        stg_v_r <= in_if.valid;
      end
      if (advance) begin
        out_v_r  <= res_v;
        phase_r  <= phase_nxt;
        esc_r    <= esc_nxt;
        ctrl_r   <= ctrl_nxt;
        par_r    <= par_nxt;
        held_r   <= held_nxt;
        held_v_r <= held_v_nxt;
        cnt_r    <= cnt_nxt;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      stg_byte_r <= in_if.rx_byte;
    end
    if (advance) begin
      out_st_r   <= res_st;
      out_data_r <= res_data;
      out_ctrl_r <= ctrl_r;
      out_len_r  <= res_len;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.status       = out_st_r;
  assign out_if.data_byte    = out_data_r;
  assign out_if.control_byte = out_ctrl_r;
  assign out_if.frame_length = out_len_r;

`ifndef SYNTHESIS
  a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_st_r != ST_GOOD)) |-> (out_len_r == 9'd0))
    else $error("frame length set on a non-good result");

  a_data_only_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_st_r != ST_BYTE)) |-> (out_data_r == 8'h00))
    else $error("data byte set on a status result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= LIMIT_C)
    else $error("payload count beyond limit");

  a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> ((phase_r == PH_HDR) || (phase_r == PH_DATA)))
    else $error("escape pending outside header check or payload");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(cnt_r) && $stable(par_r))
    else $error("frame state moved without an advancing request");
`endif

endmodule

FILE: hdl/byte_stuffed_frame_receiver_unit.sv
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    rx_byte[7:0] raw line byte
// out_if    out  valid/ready    status[2:0] data_byte[7:0] control_byte[7:0]
//                               frame_length[8:0]
// cfg_if    in   valid/ready    index[0] data[8:0] (0 address, 1 max payload)
//
// One request per cycle while results are taken; a byte's result register is
// loaded from the input stage by one pass of deframing logic.
// Payload bytes appear one line byte late: the byte before a closing flag is
// the data check byte and is never shown as payload.
// rst_n is synchronous, active low; registers return to their reset values
// and the deframer hunts for a flag.
// A stalled result stalls the input stage only; cfg_if is always ready.
module byte_stuffed_frame_receiver_unit #(
  parameter int PAYLOAD_LIMIT = bsfr_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsfr_in_if.sink    in_if,
  bsfr_out_if.source out_if,
  bsfr_cfg_if.sink   cfg_if
);
  import bsfr_pkg::*;

  cfg_t cfg;

  // address and payload limit registers
  bsfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // flag hunt, header check, destuffing and data check
  bsfr_deframer #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_deframer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

FILE: tb/byte_stuffed_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module byte_stuffed_frame_receiver_unit_tb;
  import bsfr_pkg::*;

  localparam int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF;
  localparam int SETTLE_CYCLES = 8;        // pipeline is two deep; allow slack
  localparam int PHASE_BYTES   = 150;      // random line bytes per register setting
  localparam int NUM_SETTINGS  = 8;
  localparam int HOLD_CYCLES   = 300;      // long result hold-off, fills the block
  localparam int RUN_LIMIT_NS  = 4_000_000;

  // Deframer states of the predictor (its own encoding, never compared)
  typedef enum logic [2:0] {RX_HUNT, RX_ADDR, RX_CTRL, RX_HDR, RX_DATA} rx_state_t;

  // Shapes of generated line traffic
  typedef enum int {
    FR_GOOD, FR_WRONG_ADDR, FR_BAD_HDR, FR_HDR_ESC, FR_DATA_ESC,
    FR_BAD_CHECK, FR_NO_CHECK, FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic [7:0] ctrl;
    logic [8:0] len;
  } frame_res_t;

  // One row of the directed line: the byte, and where the outcome is obvious,
  // the status, control field and length typed in. Other rows use the predictor.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    status_t    st;
    logic [7:0] ctrl;
    logic [8:0] len;
  } dir_row_t;

  // Register defaults hold here: address 0x03, payload limit 250.
  localparam dir_row_t DIR_TAB [34] = '{
    // repeated flag, control byte equal to the flag, flag where the header
    // check belongs (restart at the address)
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    // same header again, check 0x7D arrives escaped, empty payload, check 0x00
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7D, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h5D, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h00, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b1, ST_GOOD,     8'h7E, 9'd0},
    // wrong address drops back to hunting
    '{8'hFF, 1'b0, ST_BYTE,     8'h00, 9'd0},
    // payload 0xFF and an escaped 0x7E, check 0x81
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h00, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'hFF, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7D, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h5E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h81, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b1, ST_GOOD,     8'h00, 9'd2},
    // header check mismatch
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h01, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h05, 1'b1, ST_HDR_ERR,  8'h01, 9'd0},
    // escape then flag in the payload; the flag opens the next frame
    '{8'h7E, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h00, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7D, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b1, ST_BAD_ESC,  8'h00, 9'd0},
    // closing flag straight after the header: no check byte held
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h00, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h03, 1'b0, ST_BYTE,     8'h00, 9'd0},
    '{8'h7E, 1'b1, ST_DATA_ERR, 8'h00, 9'd0}
  };

  logic clk;
  logic rst_n;

  bsfr_in_if  in_if ();
  bsfr_out_if out_if ();
  bsfr_cfg_if cfg_if ();

  byte_stuffed_frame_receiver_unit #(
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of registers and deframer state
  // ---------------------------------------------------------------------------
  logic [7:0] cfg_addr;
  logic [8:0] cfg_max;
  rx_state_t  rx_state;
  logic       esc_armed;
  logic [7:0] ctrl_seen;
  logic [7:0] xor_acc;      // XOR of payload bytes already released
  logic [7:0] delay_byte;   // destuffed byte held back one step
  logic       delay_full;
  int         pay_count;

  frame_res_t deframed_q [$];   // results still owed by the block
  logic [7:0] line_q [$];       // line bytes of the frame being built

  // Run bookkeeping
  int bytes_sent;
  int mismatches;
  int payload_seen;
  int good_seen;
  int errors_seen;
  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  function automatic int payload_cap();
    return (cfg_max < PAYLOAD_LIMIT) ? int'(cfg_max) : PAYLOAD_LIMIT;
  endfunction

  function automatic frame_res_t mk_res(input status_t s, input logic [7:0] d,
                                        input logic [8:0] n);
    frame_res_t t;
    t.status = s;
    t.data   = d;
    t.ctrl   = ctrl_seen;
    t.len    = n;
    return t;
  endfunction

  // 0x5E -> 0x7E, 0x5D -> 0x7D; anything else is a broken escape
  function automatic bit unstuff(input logic [7:0] b, output logic [7:0] d);
    d = b;
    if (b == (FLAG_BYTE ^ ESC_XOR)) begin
      d = FLAG_BYTE;
      return 1'b1;
    end
    if (b == (ESC_BYTE ^ ESC_XOR)) begin
      d = ESC_BYTE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // New destuffed byte comes in; the one held back goes out (or overflows)
  function automatic bit release_held(input logic [7:0] d, output frame_res_t r);
    bit has;
    has = 1'b0;
    r   = mk_res(ST_BYTE, 8'h00, 9'd0);
    if (delay_full) begin
      if (pay_count >= payload_cap()) begin
        rx_state   = RX_HUNT;
        delay_full = 1'b0;
        r = mk_res(ST_OVERFLOW, 8'h00, 9'd0);
        return 1'b1;
      end
      r = mk_res(ST_BYTE, delay_byte, 9'd0);
      xor_acc = xor_acc ^ delay_byte;
      pay_count++;
      has = 1'b1;
    end
    delay_byte = d;
    delay_full = 1'b1;
    return has;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t r);
    logic [7:0] d;
    r = mk_res(ST_BYTE, 8'h00, 9'd0);
    case (rx_state)
      RX_ADDR: begin
        // address match wins even when the address is the flag itself
        if (b == cfg_addr) rx_state = RX_CTRL;
        else if (b != FLAG_BYTE) rx_state = RX_HUNT;
        return 1'b0;
      end
      RX_CTRL: begin
        ctrl_seen = b;
        esc_armed = 1'b0;
        rx_state  = RX_HDR;
        return 1'b0;
      end
      RX_HDR: begin
        d = b;
        if (esc_armed) begin
          esc_armed = 1'b0;
          if (!unstuff(b, d)) begin
            rx_state = (b == FLAG_BYTE) ? RX_ADDR : RX_HUNT;
            r = mk_res(ST_BAD_ESC, 8'h00, 9'd0);
            return 1'b1;
          end
        end else if (b == ESC_BYTE) begin
          esc_armed = 1'b1;
          return 1'b0;
        end else if (b == FLAG_BYTE) begin
          rx_state = RX_ADDR;
          return 1'b0;
        end
        if (d == (cfg_addr ^ ctrl_seen)) begin
          rx_state   = RX_DATA;
          xor_acc    = 8'h00;
          delay_byte = 8'h00;
          delay_full = 1'b0;
          pay_count  = 0;
          return 1'b0;
        end
        rx_state = RX_HUNT;
        r = mk_res(ST_HDR_ERR, 8'h00, 9'd0);
        return 1'b1;
      end
      RX_DATA: begin
        if (esc_armed) begin
          esc_armed = 1'b0;
          if (!unstuff(b, d)) begin
            rx_state   = (b == FLAG_BYTE) ? RX_ADDR : RX_HUNT;
            delay_full = 1'b0;
            r = mk_res(ST_BAD_ESC, 8'h00, 9'd0);
            return 1'b1;
          end
          return release_held(d, r);
        end
        if (b == ESC_BYTE) begin
          esc_armed = 1'b1;
          return 1'b0;
        end
        if (b == FLAG_BYTE) begin
          // held byte is the check byte; none held counts as a check error
          rx_state = RX_ADDR;
          if (delay_full && delay_byte == xor_acc)
            r = mk_res(ST_GOOD, 8'h00, pay_count[8:0]);
          else
            r = mk_res(ST_DATA_ERR, 8'h00, 9'd0);
          delay_full = 1'b0;
          return 1'b1;
        end
        return release_held(b, r);
      end
      default: begin
        esc_armed = 1'b0;
        rx_state  = (b == FLAG_BYTE) ? RX_ADDR : RX_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Line traffic generation
  // ---------------------------------------------------------------------------

  // Random byte, leaning towards the framing codes and the extremes
  function automatic logic [7:0] line_byte();
    if ($urandom_range(7) != 0) return 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      2:       return FLAG_BYTE ^ ESC_XOR;
      3:       return ESC_BYTE ^ ESC_XOR;
      4:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // Byte that makes an escape illegal: a flag, or anything but 0x5E/0x5D
  function automatic logic [7:0] broken_escape();
    logic [7:0] v;
    if ($urandom_range(3) == 0) return FLAG_BYTE;
    v = 8'($urandom_range(255));
    if (v == (FLAG_BYTE ^ ESC_XOR) || v == (ESC_BYTE ^ ESC_XOR)) v = v ^ 8'h01;
    return v;
  endfunction

  function automatic void put_stuffed(input logic [7:0] v);
    if (v == FLAG_BYTE || v == ESC_BYTE) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(v ^ ESC_XOR);
    end else begin
      line_q.push_back(v);
    end
  endfunction

  // Build one frame (or a burst of noise) into line_q
  function automatic void build_frame(input frame_kind_t kind, input int plen);
    logic [7:0] ctrl;
    logic [7:0] acc;
    logic [7:0] d;
    int         cut;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(line_byte());
      return;
    end
    line_q.push_back(FLAG_BYTE);
    if ($urandom_range(7) == 0) line_q.push_back(FLAG_BYTE);
    if (kind == FR_WRONG_ADDR) line_q.push_back(cfg_addr ^ 8'($urandom_range(1, 255)));
    else line_q.push_back(cfg_addr);
    ctrl = line_byte();
    line_q.push_back(ctrl);           // control goes out raw
    case (kind)
      FR_BAD_HDR: put_stuffed(cfg_addr ^ ctrl ^ 8'($urandom_range(1, 255)));
      FR_HDR_ESC: begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(broken_escape());
        return;
      end
      default:    put_stuffed(cfg_addr ^ ctrl);
    endcase
    cut = (kind == FR_DATA_ESC) ? $urandom_range(0, plen) : -1;
    acc = 8'h00;
    for (int i = 0; i <= plen; i++) begin
      if (i == cut) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(broken_escape());
        return;
      end
      if (i < plen) begin
        d   = line_byte();
        acc = acc ^ d;
        put_stuffed(d);
      end
    end
    case (kind)
      FR_NO_CHECK:  ;
      FR_BAD_CHECK: put_stuffed(acc ^ 8'($urandom_range(1, 255)));
      default:      put_stuffed(acc);
    endcase
    line_q.push_back(FLAG_BYTE);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (change on the falling edge, sample on the rising edge)
  // ---------------------------------------------------------------------------

  // Offer one line byte; on acceptance, work out what the block owes for it.
  // A typed expectation replaces the predictor's result for directed rows.
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t typed_res);
    int         gap;
    bit         has;
    frame_res_t r;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    has = deframe_byte(b, r);
    if (typed) deframed_q.push_back(typed_res);
    else if (has) deframed_q.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front(), 1'b0, '0);
  endtask

  // Nothing owed, and the last byte (which may cause no result) has passed through
  task automatic wait_idle();
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_EXP_ADDR) cfg_addr = val[7:0];
    else cfg_max = val;
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [8:0] maxp);
    wait_idle();
    write_reg(REG_EXP_ADDR, {1'b0, addr});
    write_reg(REG_MAX_PAYLOAD, maxp);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  // The sender keeps offering meanwhile, so the block backs up onto in_if.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    frame_res_t want;
    frame_res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status = status_t'(out_if.status);
      got.data   = out_if.data_byte;
      got.ctrl   = out_if.control_byte;
      got.len    = out_if.frame_length;
      case (got.status)
        ST_BYTE: payload_seen++;
        ST_GOOD: good_seen++;
        default: errors_seen++;
      endcase
      if (deframed_q.size() == 0) begin
        flag_error($sformatf("%0t: unexpected result status %0d data %02h ctrl %02h len %0d",
                             $realtime, got.status, got.data, got.ctrl, got.len));
      end else begin
        want = deframed_q.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.ctrl !== want.ctrl || got.len !== want.len)
          flag_error($sformatf({"%0t: mismatch exp status %0d data %02h ctrl %02h len %0d,",
                                " got status %0d data %02h ctrl %02h len %0d"},
                               $realtime, want.status, want.data, want.ctrl, want.len,
                               got.status, got.data, got.ctrl, got.len));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_res_t  row_res;
    logic [7:0]  set_addr;
    logic [8:0]  set_max;
    int          start;
    int          pick;
    int          plen;
    frame_kind_t kind;

    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_EXP_ADDR;
    cfg_if.data   = 9'd0;
    rst_n         = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    bytes_sent    = 0;
    mismatches    = 0;
    payload_seen  = 0;
    good_seen     = 0;
    errors_seen   = 0;

    // predictor at its reset state
    cfg_addr   = EXP_ADDR_RST;
    cfg_max    = MAX_PAYLOAD_RST;
    rx_state   = RX_HUNT;
    esc_armed  = 1'b0;
    ctrl_seen  = 8'h00;
    xor_acc    = 8'h00;
    delay_byte = 8'h00;
    delay_full = 1'b0;
    pay_count  = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed line at the register defaults, no idling
    foreach (DIR_TAB[i]) begin
      row_res = '{DIR_TAB[i].st, 8'h00, DIR_TAB[i].ctrl, DIR_TAB[i].len};
      send_byte(DIR_TAB[i].rx, DIR_TAB[i].typed, row_res);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    // Random frames under a run of register settings and idling patterns
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0:       begin set_addr = 8'h03; set_max = 9'd250; end
        1:       begin set_addr = 8'h00; set_max = 9'd1;   end
        2:       begin set_addr = 8'hFF; set_max = 9'd256; end
        3:       begin set_addr = FLAG_BYTE; set_max = 9'd0; end  // any frame with a payload overflows
        4:       begin set_addr = ESC_BYTE;  set_max = 9'd8; end
        5:       begin
          set_addr = 8'($urandom_range(255));
          set_max  = 9'($urandom_range(1, 256));
        end
        6:       begin
          set_addr = 8'($urandom_range(255));
          set_max  = 9'($urandom_range(1, 20));
        end
        default: begin set_addr = EXP_ADDR_RST; set_max = MAX_PAYLOAD_RST; end
      endcase
      set_config(set_addr, set_max);

      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (p == 1) hold_req++;

      // full-size frame, then one byte too many
      if (payload_cap() == PAYLOAD_LIMIT) begin
        build_frame(FR_GOOD, PAYLOAD_LIMIT);
        build_frame(FR_GOOD, PAYLOAD_LIMIT + 1);
        send_line();
      end

      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if      (pick < 62) kind = FR_GOOD;
        else if (pick < 67) kind = FR_WRONG_ADDR;
        else if (pick < 72) kind = FR_BAD_HDR;
        else if (pick < 77) kind = FR_HDR_ESC;
        else if (pick < 83) kind = FR_DATA_ESC;
        else if (pick < 89) kind = FR_BAD_CHECK;
        else if (pick < 94) kind = FR_NO_CHECK;
        else                kind = FR_NOISE;
        // mostly short payloads; near the limit only when the limit is small
        pick = $urandom_range(99);
        if (pick < 10)      plen = 0;
        else if (pick < 75) plen = $urandom_range(1, 8);
        else if (pick < 90) plen = $urandom_range(9, 24);
        else if (payload_cap() <= 32)
          plen = $urandom_range((payload_cap() > 0) ? payload_cap() - 1 : 0, payload_cap() + 2);
        else plen = $urandom_range(1, 8);
        build_frame(kind, plen);
        send_line();
      end
      @(negedge clk);
      in_if.valid <= 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Deframer: %0d line bytes over %0d register settings, four idling patterns",
             bytes_sent, NUM_SETTINGS + 1);
    $display("  checked %0d payload bytes, %0d good frames, %0d error statuses; %0d mismatches",
             payload_seen, good_seen, errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("Deframer run timed out, %0d results outstanding", deframed_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
